@@ design/bfa_pkg.sv @@
// ============================================================================
// bfa_pkg
// Types and constants shared by the bitmap first-fit allocator.
// ============================================================================
`default_nettype none

package bfa_pkg;

    localparam int MAP_ENTRIES_DEF = 4096;
    localparam int WORD_BITS_DEF   = 64;

    localparam int IDX_W   = 12;
    localparam int COUNT_W = 13;
    localparam int STAT_W  = 2;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] entry_index;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   granted_index;
        logic [COUNT_W-1:0] used_count;
    } t_rsp;

endpackage

`default_nettype wire

@@ design/bfa_ram.sv @@
// ============================================================================
// bfa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/bfa_first_zero.sv @@
// ============================================================================
// bfa_first_zero
// Priority encoder: position of the lowest clear bit of one map word.
// ============================================================================
`default_nettype none

module bfa_first_zero #(
    parameter int WORD_BITS = 64
) (
    input  wire logic [WORD_BITS-1:0]         i_word,
    output logic                              o_found,
    output logic [$clog2(WORD_BITS)-1:0]      o_bit
);

    localparam int BIT_W = $clog2(WORD_BITS);

    always_comb begin
        o_found = 1'b0;
        o_bit   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!i_word[b]) begin
                o_found = 1'b1;
                o_bit   = BIT_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/bitmap_first_fit_allocator.sv @@
// ============================================================================
// bitmap_first_fit_allocator
// First-fit bitmap allocator: occupancy words in a RAM, read-modify-write.
//
//   channel   signals                 direction  notes
//   request   start, busy, i_req      in         taken when start && !busy
//   response  o_valid, o_rsp          out        one-cycle strobe, no stall
//
// Allocate: words are read from the lowest word that may hold a clear bit
// (one RAM read per cycle) up to the first word with a clear bit.
// Free: index split into word and bit, RAM read, check and write.
// Free of an out-of-range index: answered from idle, no RAM access.
// After reset the RAM is cleared one word per cycle, all MAP_WORDS words, with
// busy high. The response appears the cycle after the item's last step.
// ============================================================================
`default_nettype none

module bitmap_first_fit_allocator #(
    parameter int MAP_ENTRIES = bfa_pkg::MAP_ENTRIES_DEF,
    parameter int WORD_BITS   = bfa_pkg::WORD_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire bfa_pkg::t_req i_req,
    output logic               o_valid,
    output bfa_pkg::t_rsp      o_rsp
);

    localparam int MAP_WORDS  = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW         = $clog2(WORD_BITS);
    localparam int CW         = $clog2(MAP_ENTRIES + 1);
    localparam int IW         = $clog2(MAP_WORDS * WORD_BITS);
    localparam int XW         = bfa_pkg::IDX_W;
    localparam int RECIP      = (1 << XW) / WORD_BITS;
    localparam int RW         = $clog2(RECIP + 1);
    localparam int PW         = XW + RW;
    localparam int LAST_VALID = MAP_ENTRIES - (MAP_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_PAD = {WORD_BITS{1'b1}} << LAST_VALID;
    localparam logic [AW-1:0]        LAST_WORD = AW'(MAP_WORDS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_FDIV  = 6'b001000,
        S_FRD   = 6'b010000,
        S_FCHK  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [XW-1:0]      r_idx, n_idx;
    logic [RW-1:0]      r_q, n_q;
    logic [AW-1:0]      r_addr, n_addr;
    logic [BW-1:0]      r_bit, n_bit;
    logic [AW-1:0]      r_low, n_low;
    logic [CW-1:0]      r_count, n_count;
    logic               r_valid, n_valid;
    bfa_pkg::t_rsp      r_rsp, n_rsp;

    logic [AW-1:0]        rd_addr;
    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] scan_word;
    logic                 zero_found;
    logic [BW-1:0]        zero_bit;
    logic [PW-1:0]        prod;
    logic [XW:0]          q_times_wb;
    logic [XW-1:0]        rem;
    logic [RW:0]          fword;
    logic [XW-1:0]        fbit;
    logic [IW-1:0]        granted;
    logic                 out_of_range;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign scan_word = rdata | ((r_addr == LAST_WORD) ? LAST_PAD : '0);

    bfa_first_zero #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .i_word  (scan_word),
        .o_found (zero_found),
        .o_bit   (zero_bit)
    );

    // index to word/bit: reciprocal estimate, then one correction step
    assign prod       = PW'(r_idx) * PW'(RECIP);
    assign q_times_wb = (XW + 1)'(r_q) * (XW + 1)'(WORD_BITS);
    assign rem        = r_idx - q_times_wb[XW-1:0];

    always_comb begin
        if (rem >= XW'(WORD_BITS)) begin
            fword = (RW + 1)'(r_q) + 1'b1;
            fbit  = rem - XW'(WORD_BITS);
        end else begin
            fword = (RW + 1)'(r_q);
            fbit  = rem;
        end
    end

    assign granted      = IW'(r_addr) * IW'(WORD_BITS) + IW'(zero_bit);
    assign out_of_range = 32'(i_req.entry_index) >= 32'(MAP_ENTRIES);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_q     = r_q;
        n_addr  = r_addr;
        n_bit   = r_bit;
        n_low   = r_low;
        n_count = r_count;
        n_valid = 1'b0;
        n_rsp   = r_rsp;
        rd_addr = r_addr;
        we      = 1'b0;
        wdata   = '0;

        unique case (r_state)
            S_CLEAR: begin
                we     = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                    n_low   = '0;
                end
            end
            S_IDLE: begin
                rd_addr = r_low;
                if (start) begin
                    n_idx = i_req.entry_index;
                    if (i_req.cmd == bfa_pkg::CMD_ALLOC) begin
                        n_addr  = r_low;
                        n_state = S_SCAN;
                    end else if (out_of_range) begin
                        n_valid             = 1'b1;
                        n_rsp.status        = bfa_pkg::ST_BAD_FREE;
                        n_rsp.granted_index = '0;
                        n_rsp.used_count    = bfa_pkg::COUNT_W'(r_count);
                    end else begin
                        n_state = S_FDIV;
                    end
                end
            end
            S_SCAN: begin
                rd_addr = r_addr + 1'b1;
                if (zero_found) begin
                    we                  = 1'b1;
                    wdata               = rdata | (WORD_BITS'(1) << zero_bit);
                    n_low               = r_addr;
                    n_count             = r_count + 1'b1;
                    n_valid             = 1'b1;
                    n_rsp.status        = bfa_pkg::ST_DONE;
                    n_rsp.granted_index = bfa_pkg::IDX_W'(granted);
                    n_rsp.used_count    = bfa_pkg::COUNT_W'(r_count + 1'b1);
                    n_state             = S_IDLE;
                end else if (r_addr == LAST_WORD) begin
                    n_valid             = 1'b1;
                    n_rsp.status        = bfa_pkg::ST_FULL;
                    n_rsp.granted_index = '0;
                    n_rsp.used_count    = bfa_pkg::COUNT_W'(r_count);
                    n_state             = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_FDIV: begin
                n_q     = prod[PW-1:XW];
                n_state = S_FRD;
            end
            S_FRD: begin
                n_addr  = AW'(fword);
                n_bit   = BW'(fbit);
                rd_addr = AW'(fword);
                n_state = S_FCHK;
            end
            S_FCHK: begin
                n_valid             = 1'b1;
                n_rsp.granted_index = '0;
                n_state             = S_IDLE;
                if (rdata[r_bit]) begin
                    we               = 1'b1;
                    wdata            = rdata & ~(WORD_BITS'(1) << r_bit);
                    n_count          = r_count - 1'b1;
                    n_rsp.status     = bfa_pkg::ST_DONE;
                    n_rsp.used_count = bfa_pkg::COUNT_W'(r_count - 1'b1);
                    if (r_addr < r_low) begin
                        n_low = r_addr;
                    end
                end else begin
                    n_rsp.status     = bfa_pkg::ST_BAD_FREE;
                    n_rsp.used_count = bfa_pkg::COUNT_W'(r_count);
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_low   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_low   <= n_low;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_q   <= n_q;
        r_bit <= n_bit;
        r_rsp <= n_rsp;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire
